FILE: hw/rtl/wwss_pkg.sv
// Package with the types and constants of the well wash step sequencer.
package wwss_pkg;

  // Step phases as reported on the result channel.
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START    = 4'd1;
  localparam logic [3:0] PH_MOVE_X   = 4'd2;
  localparam logic [3:0] PH_FILL     = 4'd3;
  localparam logic [3:0] PH_Z_BOTTOM = 4'd4;
  localparam logic [3:0] PH_SHAKE    = 4'd5;
  localparam logic [3:0] PH_Z_TOP    = 4'd6;
  localparam logic [3:0] PH_DRAIN    = 4'd7;
  localparam logic [3:0] PH_WAIT     = 4'd8;
  localparam logic [3:0] PH_FINISH   = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] CFG_X_WELL_TARGET       = 3'd0;
  localparam logic [2:0] CFG_Z_BOTTOM            = 3'd1;
  localparam logic [2:0] CFG_WAIT_AFTER_MOVE_S   = 3'd2;
  localparam logic [2:0] CFG_WAIT_AFTER_BOTTOM_S = 3'd3;
  localparam logic [2:0] CFG_SHAKE_TIME_S        = 3'd4;
  localparam logic [2:0] CFG_WAIT_AFTER_SHAKE_S  = 3'd5;
  localparam logic [2:0] CFG_WAIT_FINAL_S        = 3'd6;
  localparam logic [2:0] CFG_STEP_OPTIONS        = 3'd7;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [9:0]  MS_PER_S    = 10'd1000;
  localparam logic [31:0] SHAKE_SWING = 32'd1000;

  // Option bits of step_options.
  localparam int unsigned OPT_FILL  = 0;
  localparam int unsigned OPT_DRAIN = 1;

  typedef struct packed {
    logic [31:0] x_well_target;
    logic [31:0] z_bottom;
    logic [15:0] wait_after_move_s;
    logic [15:0] wait_after_bottom_s;
    logic [15:0] shake_time_s;
    logic [15:0] wait_after_shake_s;
    logic [15:0] wait_final_s;
    logic [1:0]  step_options;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [31:0] x_position;
    logic [31:0] z_position;
    logic        level_full;
    logic        level_empty;
  } item_t;

  typedef struct packed {
    logic        x_move_valid;
    logic [31:0] x_move_target;
    logic        z_move_valid;
    logic [31:0] z_move_target;
    logic        pump_on;
    logic        drain_active;
    logic [3:0]  phase;
    logic        step_done;
  } result_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  phase_before_wait;
    logic [31:0] deadline_ms;
    logic        pump_on;
  } seq_state_t;

endpackage

FILE: hw/rtl/wwss_if.sv
// Channel interfaces for poll items and step results.
interface wwss_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] now_ms;
  logic [31:0] x_position;
  logic [31:0] z_position;
  logic        level_full;
  logic        level_empty;

  modport source (output valid, command, now_ms, x_position, z_position,
                  level_full, level_empty, input ready);
  modport sink (input valid, command, now_ms, x_position, z_position,
                level_full, level_empty, output ready);
endinterface

interface wwss_out_if;
  logic        valid;
  logic        ready;
  logic        x_move_valid;
  logic [31:0] x_move_target;
  logic        z_move_valid;
  logic [31:0] z_move_target;
  logic        pump_on;
  logic        drain_active;
  logic [3:0]  phase;
  logic        step_done;

  modport source (output valid, x_move_valid, x_move_target, z_move_valid,
                  z_move_target, pump_on, drain_active, phase, step_done,
                  input ready);
  modport sink (input valid, x_move_valid, x_move_target, z_move_valid,
                z_move_target, pump_on, drain_active, phase, step_done,
                output ready);
endinterface

FILE: hw/rtl/wwss_step.sv
// Next-state and result logic for one poll item of the wash step.
module wwss_step
  import wwss_pkg::*;
(
  input  cfg_t       cfg,
  input  item_t      item,
  input  seq_state_t st,
  output seq_state_t st_nxt,
  output result_t    res
);

  logic [31:0] low_point;
  logic        passed;
  logic        load_dl;
  logic [15:0] secs_sel;
  logic [25:0] dl_ofs;

  assign low_point = cfg.z_bottom - SHAKE_SWING;
  assign passed    = item.now_ms > st.deadline_ms;
  // A 16-bit count of seconds times 1000 fits in 26 bits.
  assign dl_ofs    = 26'(secs_sel * MS_PER_S);

  always_comb begin
    st_nxt   = st;
    res      = '0;
    load_dl  = 1'b0;
    secs_sel = '0;

    unique case (st.phase)
      PH_IDLE: begin
        if (item.command) st_nxt.phase = PH_START;
      end
      PH_START: begin
        res.x_move_valid  = 1'b1;
        res.x_move_target = cfg.x_well_target;
        st_nxt.phase      = PH_MOVE_X;
      end
      PH_MOVE_X: begin
        if (item.x_position == cfg.x_well_target) begin
          st_nxt.phase_before_wait = PH_MOVE_X;
          st_nxt.phase             = PH_WAIT;
          load_dl                  = 1'b1;
          secs_sel                 = cfg.wait_after_move_s;
        end
      end
      PH_FILL: begin
        if (item.level_full) begin
          res.z_move_valid  = 1'b1;
          res.z_move_target = cfg.z_bottom;
          st_nxt.phase      = PH_Z_BOTTOM;
          st_nxt.pump_on    = 1'b0;
        end
      end
      PH_Z_BOTTOM: begin
        if (item.z_position == cfg.z_bottom) begin
          st_nxt.phase_before_wait = PH_Z_BOTTOM;
          st_nxt.phase             = PH_WAIT;
          load_dl                  = 1'b1;
          secs_sel                 = cfg.wait_after_bottom_s;
        end
      end
      PH_SHAKE: begin
        if (item.z_position == low_point) begin
          res.z_move_valid  = 1'b1;
          res.z_move_target = cfg.z_bottom;
        end
        if (item.z_position == cfg.z_bottom) begin
          if (passed) begin
            st_nxt.phase_before_wait = PH_SHAKE;
            st_nxt.phase             = PH_WAIT;
            load_dl                  = 1'b1;
            secs_sel                 = cfg.wait_after_shake_s;
          end else begin
            res.z_move_valid  = 1'b1;
            res.z_move_target = low_point;
          end
        end
      end
      PH_Z_TOP: begin
        if (item.z_position == '0) begin
          st_nxt.phase_before_wait = PH_Z_TOP;
          if (cfg.step_options[OPT_DRAIN]) begin
            st_nxt.phase = PH_DRAIN;
          end else begin
            st_nxt.phase = PH_WAIT;
            load_dl      = 1'b1;
            secs_sel     = cfg.wait_final_s;
          end
        end
      end
      PH_DRAIN: begin
        if (item.level_empty) begin
          st_nxt.phase_before_wait = PH_DRAIN;
          st_nxt.phase             = PH_WAIT;
          load_dl                  = 1'b1;
          secs_sel                 = cfg.wait_final_s;
        end
      end
      PH_WAIT: begin
        if (passed) begin
          unique case (st.phase_before_wait) inside
            PH_MOVE_X: begin
              if (cfg.step_options[OPT_FILL]) begin
                st_nxt.phase   = PH_FILL;
                st_nxt.pump_on = 1'b1;
              end else begin
                res.z_move_valid  = 1'b1;
                res.z_move_target = cfg.z_bottom;
                st_nxt.phase      = PH_Z_BOTTOM;
              end
            end
            PH_Z_BOTTOM: begin
              res.z_move_valid  = 1'b1;
              res.z_move_target = low_point;
              st_nxt.phase      = PH_SHAKE;
              load_dl           = 1'b1;
              secs_sel          = cfg.shake_time_s;
            end
            PH_SHAKE: begin
              res.z_move_valid  = 1'b1;
              res.z_move_target = '0;
              st_nxt.phase      = PH_Z_TOP;
            end
            PH_Z_TOP, PH_DRAIN: begin
              st_nxt.phase = PH_FINISH;
            end
            default: begin
              // An unknown return phase keeps the block waiting.
            end
          endcase
        end
      end
      PH_FINISH: begin
        st_nxt.phase  = PH_IDLE;
        res.step_done = 1'b1;
      end
      default: begin
        // Codes outside the step are held without action.
      end
    endcase

    if (load_dl) st_nxt.deadline_ms = item.now_ms + 32'(dl_ofs);

    res.pump_on      = st_nxt.pump_on;
    res.drain_active = (st_nxt.phase == PH_DRAIN);
    res.phase        = st_nxt.phase;
  end

endmodule

FILE: hw/rtl/well_wash_step_sequencer.sv
// Top level of the well wash step sequencer.
//
// Poll items arrive on in_ch (valid/ready): a command (poll or start),
// the millisecond tick, the X and Z positions and the two level sensors.
// Each item yields exactly one result on out_ch: the motor target writes
// issued by that item, pump drive, drain flag, the phase after the item
// and a done pulse on the item that leaves finish.
// The cfg_ port writes the eight step registers; write them only while
// no transaction is in flight.
// An accepted item sits in an input register, the phase logic then runs
// in a single pass into the result register, so each item passes the
// input register and then the result register before out_ch offers its
// result. One item per cycle is taken in sustained operation while
// out_ch is ready; the phase state is updated as each item moves into
// the result register, so the next item already sees it.
// When the receiver stalls, the result register holds and the input
// register still fills, after which in_ch.ready drops until out_ch moves.
// Synchronous reset clears the step registers and the state, empties both
// stages and puts the sequence in idle with the pump off and the deadline at zero.
module well_wash_step_sequencer
  import wwss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  wwss_in_if.sink                in_ch,
  wwss_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t       cfg_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  item_t      item_r;
  logic       item_valid_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       out_valid_r;
  logic       in_fire;
  logic       advance;

  assign advance   = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;
  assign in_fire   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_WELL_TARGET:       cfg_r.x_well_target       <= cfg_wdata;
        CFG_Z_BOTTOM:            cfg_r.z_bottom            <= cfg_wdata;
        CFG_WAIT_AFTER_MOVE_S:   cfg_r.wait_after_move_s   <= cfg_wdata[15:0];
        CFG_WAIT_AFTER_BOTTOM_S: cfg_r.wait_after_bottom_s <= cfg_wdata[15:0];
        CFG_SHAKE_TIME_S:        cfg_r.shake_time_s        <= cfg_wdata[15:0];
        CFG_WAIT_AFTER_SHAKE_S:  cfg_r.wait_after_shake_s  <= cfg_wdata[15:0];
        CFG_WAIT_FINAL_S:        cfg_r.wait_final_s        <= cfg_wdata[15:0];
        CFG_STEP_OPTIONS:        cfg_r.step_options        <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.command     <= in_ch.command;
      item_r.now_ms      <= in_ch.now_ms;
      item_r.x_position  <= in_ch.x_position;
      item_r.z_position  <= in_ch.z_position;
      item_r.level_full  <= in_ch.level_full;
      item_r.level_empty <= in_ch.level_empty;
    end
    if (advance) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '0;
    end else begin
      if (in_fire) begin
        item_valid_r <= 1'b1;
      end else if (advance) begin
        item_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  wwss_step u_step (
    .cfg    (cfg_r),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.x_move_valid  = res_r.x_move_valid;
  assign out_ch.x_move_target = res_r.x_move_target;
  assign out_ch.z_move_valid  = res_r.z_move_valid;
  assign out_ch.z_move_target = res_r.z_move_target;
  assign out_ch.pump_on       = res_r.pump_on;
  assign out_ch.drain_active  = res_r.drain_active;
  assign out_ch.phase         = res_r.phase;
  assign out_ch.step_done     = res_r.step_done;

endmodule

FILE: hw/rtl/wwss_checker.sv
// Port-level checks of the well wash step sequencer and their binding.
module wwss_checker
  import wwss_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        x_move_valid,
  input logic [31:0] x_move_target,
  input logic        z_move_valid,
  input logic [31:0] z_move_target,
  input logic        drain_active,
  input logic [3:0]  phase,
  input logic        step_done
);

  // A done pulse always lands the sequence back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_done |-> phase == PH_IDLE)
    else $error("step_done with a phase other than idle");

  // The drain flag mirrors the drain phase.
  a_drain_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> drain_active == (phase == PH_DRAIN))
    else $error("drain_active disagrees with phase");

  // Targets read as zero when no move is issued, and an X move only leaves start.
  a_idle_targets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (x_move_valid || x_move_target == '0) &&
                  (z_move_valid || z_move_target == '0) &&
                  (!x_move_valid || phase == PH_MOVE_X))
    else $error("move target without a move, or X move outside move X");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(step_done))
    else $error("stalled result changed");

endmodule

bind well_wash_step_sequencer wwss_checker u_wwss_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .x_move_valid  (out_ch.x_move_valid),
  .x_move_target (out_ch.x_move_target),
  .z_move_valid  (out_ch.z_move_valid),
  .z_move_target (out_ch.z_move_target),
  .drain_active  (out_ch.drain_active),
  .phase         (out_ch.phase),
  .step_done     (out_ch.step_done)
);

FILE: verif/tb.sv
// Self-checking testbench for the well wash step sequencer: directed step walk, then random polls.
module tb;
  import wwss_pkg::*;

  localparam logic CMD_POLL  = 1'b0;
  localparam logic CMD_START = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   MAX_PRINTS  = 50;

  logic clk;
  logic rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  wwss_in_if  in_ch();
  wwss_out_if out_ch();

  well_wash_step_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the step registers and the sequencing state.
  cfg_t        wash_cfg;
  logic [3:0]  step_phase;
  logic [3:0]  return_phase;
  logic [31:0] deadline_ms;
  logic        pump_state;

  item_t   pending_polls[$];
  result_t expected_results[$];

  int          error_count;
  int          cycle_count;
  bit          took_item;
  int          gap_left;
  int          burst_left;
  int          stall_mode;
  logic [31:0] gen_now_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_error(string msg);
    if (error_count < MAX_PRINTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [31:0] seconds_later(logic [31:0] now, logic [15:0] secs);
    return now + 32'(secs) * 32'(MS_PER_S);
  endfunction

  function automatic void start_wait(logic [3:0] from, logic [31:0] now, logic [15:0] secs);
    return_phase = from;
    deadline_ms  = seconds_later(now, secs);
    step_phase   = PH_WAIT;
  endfunction

  // Advances the shadow state by one poll and returns the result it should give.
  function automatic result_t wash_predict(item_t it);
    result_t     r;
    logic [31:0] low_pt;
    r = '0;
    low_pt = wash_cfg.z_bottom - SHAKE_SWING;
    if (step_phase == PH_IDLE) begin
      if (it.command == CMD_START) step_phase = PH_START;
    end else begin
      case (step_phase)
        PH_START: begin
          r.x_move_valid  = 1'b1;
          r.x_move_target = wash_cfg.x_well_target;
          step_phase      = PH_MOVE_X;
        end
        PH_MOVE_X: begin
          if (it.x_position == wash_cfg.x_well_target)
            start_wait(PH_MOVE_X, it.now_ms, wash_cfg.wait_after_move_s);
        end
        PH_FILL: begin
          if (it.level_full) begin
            r.z_move_valid  = 1'b1;
            r.z_move_target = wash_cfg.z_bottom;
            step_phase      = PH_Z_BOTTOM;
            pump_state      = 1'b0;
          end
        end
        PH_Z_BOTTOM: begin
          if (it.z_position == wash_cfg.z_bottom)
            start_wait(PH_Z_BOTTOM, it.now_ms, wash_cfg.wait_after_bottom_s);
        end
        PH_SHAKE: begin
          if (it.z_position == low_pt) begin
            r.z_move_valid  = 1'b1;
            r.z_move_target = wash_cfg.z_bottom;
          end
          // Both checks are made on every poll; the low point never equals the bottom, so at most one matches.
          if (it.z_position == wash_cfg.z_bottom) begin
            if (it.now_ms > deadline_ms) begin
              start_wait(PH_SHAKE, it.now_ms, wash_cfg.wait_after_shake_s);
            end else begin
              r.z_move_valid  = 1'b1;
              r.z_move_target = low_pt;
            end
          end
        end
        PH_Z_TOP: begin
          if (it.z_position == 32'd0) begin
            if (wash_cfg.step_options[OPT_DRAIN]) begin
              return_phase = PH_Z_TOP;
              step_phase   = PH_DRAIN;
            end else begin
              start_wait(PH_Z_TOP, it.now_ms, wash_cfg.wait_final_s);
            end
          end
        end
        PH_DRAIN: begin
          if (it.level_empty) start_wait(PH_DRAIN, it.now_ms, wash_cfg.wait_final_s);
        end
        PH_WAIT: begin
          if (it.now_ms > deadline_ms) begin
            case (return_phase)
              PH_MOVE_X: begin
                if (wash_cfg.step_options[OPT_FILL]) begin
                  step_phase = PH_FILL;
                  pump_state = 1'b1;
                end else begin
                  r.z_move_valid  = 1'b1;
                  r.z_move_target = wash_cfg.z_bottom;
                  step_phase      = PH_Z_BOTTOM;
                end
              end
              PH_Z_BOTTOM: begin
                r.z_move_valid  = 1'b1;
                r.z_move_target = low_pt;
                deadline_ms     = seconds_later(it.now_ms, wash_cfg.shake_time_s);
                step_phase      = PH_SHAKE;
              end
              PH_SHAKE: begin
                r.z_move_valid  = 1'b1;
                r.z_move_target = 32'd0;
                step_phase      = PH_Z_TOP;
              end
              PH_Z_TOP, PH_DRAIN: step_phase = PH_FINISH;
              default: ;
            endcase
          end
        end
        PH_FINISH: begin
          step_phase  = PH_IDLE;
          r.step_done = 1'b1;
        end
        default: ;
      endcase
    end
    r.pump_on      = pump_state;
    r.drain_active = (step_phase == PH_DRAIN);
    r.phase        = step_phase;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] seen, logic [31:0] want);
    if (seen !== want) flag_error($sformatf("%s got %h expected %h", name, seen, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      flag_error("result transaction with no poll outstanding");
    end else begin
      want = expected_results.pop_front();
      compare_field("x_move_valid", 32'(out_ch.x_move_valid), 32'(want.x_move_valid));
      compare_field("x_move_target", out_ch.x_move_target, want.x_move_target);
      compare_field("z_move_valid", 32'(out_ch.z_move_valid), 32'(want.z_move_valid));
      compare_field("z_move_target", out_ch.z_move_target, want.z_move_target);
      compare_field("pump_on", 32'(out_ch.pump_on), 32'(want.pump_on));
      compare_field("drain_active", 32'(out_ch.drain_active), 32'(want.drain_active));
      compare_field("phase", 32'(out_ch.phase), 32'(want.phase));
      compare_field("step_done", 32'(out_ch.step_done), 32'(want.step_done));
    end
  endtask

  // Monitor: prediction on poll acceptance, checking on result acceptance.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    took_item = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(wash_predict(pending_polls.pop_front()));
        took_item = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  // Poll driver: bursts of transactions with random gaps; a valid item is held until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !took_item)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_polls.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid       <= 1'b1;
        in_ch.command     <= pending_polls[0].command;
        in_ch.now_ms      <= pending_polls[0].now_ms;
        in_ch.x_position  <= pending_polls[0].x_position;
        in_ch.z_position  <= pending_polls[0].z_position;
        in_ch.level_full  <= pending_polls[0].level_full;
        in_ch.level_empty <= pending_polls[0].level_empty;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 3) == 0) begin
            gap_left   = 0;
            burst_left = 64;
          end else begin
            gap_left   = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
          end
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: ready follows a stall pattern drawn at random from four modes.
  always @(negedge clk) begin
    if (cycle_count % 200 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      2:       out_ch.ready <= (cycle_count % 7) < 4;
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_X_WELL_TARGET:       wash_cfg.x_well_target       = data;
      CFG_Z_BOTTOM:            wash_cfg.z_bottom            = data;
      CFG_WAIT_AFTER_MOVE_S:   wash_cfg.wait_after_move_s   = data[15:0];
      CFG_WAIT_AFTER_BOTTOM_S: wash_cfg.wait_after_bottom_s = data[15:0];
      CFG_SHAKE_TIME_S:        wash_cfg.shake_time_s        = data[15:0];
      CFG_WAIT_AFTER_SHAKE_S:  wash_cfg.wait_after_shake_s  = data[15:0];
      CFG_WAIT_FINAL_S:        wash_cfg.wait_final_s        = data[15:0];
      CFG_STEP_OPTIONS:        wash_cfg.step_options        = data[1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t c);
    write_reg(CFG_X_WELL_TARGET, c.x_well_target);
    write_reg(CFG_Z_BOTTOM, c.z_bottom);
    write_reg(CFG_WAIT_AFTER_MOVE_S, 32'(c.wait_after_move_s));
    write_reg(CFG_WAIT_AFTER_BOTTOM_S, 32'(c.wait_after_bottom_s));
    write_reg(CFG_SHAKE_TIME_S, 32'(c.shake_time_s));
    write_reg(CFG_WAIT_AFTER_SHAKE_S, 32'(c.wait_after_shake_s));
    write_reg(CFG_WAIT_FINAL_S, 32'(c.wait_final_s));
    write_reg(CFG_STEP_OPTIONS, 32'(c.step_options));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_poll(logic cmd, logic [31:0] now, logic [31:0] xpos,
                            logic [31:0] zpos, logic full, logic empty);
    item_t it;
    it.command     = cmd;
    it.now_ms      = now;
    it.x_position  = xpos;
    it.z_position  = zpos;
    it.level_full  = full;
    it.level_empty = empty;
    pending_polls.push_back(it);
  endtask

  // Random polls biased toward the positions and sensor states that move the step along.
  task automatic queue_random_polls(int count);
    logic [31:0] low_pt;
    logic [31:0] zpos;
    logic [31:0] xpos;
    int          pick;
    low_pt = wash_cfg.z_bottom - SHAKE_SWING;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) gen_now_ms = $urandom;
      else if (pick < 10) gen_now_ms += $urandom_range(0, 70000000);
      else gen_now_ms += $urandom_range(0, 1500);
      xpos = ($urandom_range(0, 9) < 6) ? wash_cfg.x_well_target : $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2: zpos = wash_cfg.z_bottom;
        3, 4:    zpos = low_pt;
        5, 6:    zpos = 32'd0;
        7:       zpos = wash_cfg.z_bottom + 32'd1;
        default: zpos = $urandom;
      endcase
      queue_poll(($urandom_range(0, 5) == 0) ? CMD_START : CMD_POLL, gen_now_ms, xpos, zpos,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    while (pending_polls.size() != 0 || expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    cfg_t        c;
    logic [31:0] low_pt;
    error_count        = 0;
    cycle_count        = 0;
    took_item          = 1'b0;
    gap_left           = 0;
    burst_left         = 0;
    stall_mode         = 0;
    wash_cfg           = '0;
    step_phase         = PH_IDLE;
    return_phase       = PH_IDLE;
    deadline_ms        = '0;
    pump_state         = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_POLL;
    in_ch.now_ms       = '0;
    in_ch.x_position   = '0;
    in_ch.z_position   = '0;
    in_ch.level_full   = 1'b0;
    in_ch.level_empty  = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through a full step with fill and drain; the bottom sits below
    // the swing so the shake low point wraps.
    c = '0;
    c.x_well_target       = 32'h1234_5678;
    c.z_bottom            = 32'd500;
    c.wait_after_move_s   = 16'd1;
    c.wait_after_bottom_s = 16'd1;
    c.shake_time_s        = 16'd1;
    c.wait_after_shake_s  = 16'd1;
    c.wait_final_s        = 16'd1;
    c.step_options        = 2'b11;
    load_settings(c);
    low_pt = c.z_bottom - SHAKE_SWING;
    queue_poll(CMD_POLL,  32'd0,    32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_START, 32'd10,   32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_START, 32'd20,   32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd30,   32'h1234_5679, 32'd0,   1'b1, 1'b1);
    queue_poll(CMD_POLL,  32'd1000, 32'h1234_5678, 32'd0,   1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd2000, 32'h1234_5678, 32'd0,   1'b1, 1'b0);
    queue_poll(CMD_POLL,  32'd2001, 32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd2100, 32'd0,         32'd500, 1'b0, 1'b1);
    queue_poll(CMD_POLL,  32'd2200, 32'd0,         32'd0,   1'b1, 1'b0);
    queue_poll(CMD_POLL,  32'd3000, 32'd0,         32'd500, 1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd4001, 32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd4500, 32'd0,         low_pt,  1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd5001, 32'd0,         32'd500, 1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd5001, 32'd0,         32'd77,  1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd5002, 32'd0,         32'd500, 1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd6003, 32'd0,         32'd500, 1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd6100, 32'd0,         32'd5,   1'b0, 1'b1);
    queue_poll(CMD_POLL,  32'd6200, 32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd6300, 32'd0,         32'd0,   1'b1, 1'b0);
    queue_poll(CMD_POLL,  32'd7000, 32'd0,         32'd0,   1'b0, 1'b1);
    queue_poll(CMD_POLL,  32'd8001, 32'd0,         32'd0,   1'b0, 1'b0);
    queue_poll(CMD_START, 32'd8100, 32'd0,         32'd0,   1'b0, 1'b0);
    // All-ones fields, then a deadline that wraps past zero.
    queue_poll(CMD_START, '1, '1, '1, 1'b1, 1'b1);
    queue_poll(CMD_POLL,  '0, '0, '0, 1'b0, 1'b0);
    queue_poll(CMD_POLL,  '1, 32'h1234_5678, '1, 1'b0, 1'b0);
    queue_poll(CMD_POLL,  32'd0,    32'd0, 32'd0, 1'b1, 1'b0);
    queue_poll(CMD_POLL,  32'd1000, 32'd0, 32'd0, 1'b0, 1'b0);
    wait_drained();

    gen_now_ms = $urandom;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        c = '1;
      end else if (p == 1) begin
        c = '0;
      end else begin
        c.x_well_target       = $urandom;
        c.z_bottom            = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1999) : $urandom;
        c.wait_after_move_s   = 16'($urandom_range(0, 3));
        c.wait_after_bottom_s = 16'($urandom_range(0, 3));
        c.shake_time_s        = 16'($urandom_range(0, 3));
        c.wait_after_shake_s  = 16'($urandom_range(0, 3));
        c.wait_final_s        = 16'($urandom_range(0, 3));
        c.step_options        = 2'(p);
      end
      load_settings(c);
      queue_random_polls(192);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
